>>> hw/rtl/square_matrix_rotator_assert.svh
// Assertion macros for the square matrix rotator.
`ifndef SQUARE_MATRIX_ROTATOR_ASSERT_SVH
`define SQUARE_MATRIX_ROTATOR_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SMR_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smr_pkg.sv
// Types and constants shared by the square matrix rotator files.
package smr_pkg;

  localparam int VALUE_W    = 32;
  localparam int SIZE_W     = 6;
  localparam int DEG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_W        = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_DEGREES = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd4;

  // floor(a * RECIP_360 >> RECIP_SHIFT) == a / 360 for a <= 32768
  localparam logic [31:0] RECIP_360    = 32'd46604;
  localparam int          RECIP_SHIFT  = 24;
  localparam logic [15:0] FULL_TURN    = 16'd360;
  localparam logic [15:0] QUARTER_TURN = 16'd90;

  localparam logic [1:0] TURN_0   = 2'd0;
  localparam logic [1:0] TURN_90  = 2'd1;
  localparam logic [1:0] TURN_180 = 2'd2;
  localparam logic [1:0] TURN_270 = 2'd3;

endpackage

>>> hw/rtl/smr_if.sv
// Request, response and configuration channel interfaces.
interface smr_req_if;
  import smr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] element_value;
  modport source (output valid, op, element_value, input ready);
  modport sink (input valid, op, element_value, output ready);
endinterface

interface smr_rsp_if;
  import smr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic                      last_element;
  logic                      not_ready;
  modport source (output valid, result_value, last_element, not_ready, input ready);
  modport sink (input valid, result_value, last_element, not_ready, output ready);
endinterface

interface smr_cfg_if;
  import smr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/square_matrix_rotator.sv
// Square matrix rotator: loads an n-by-n matrix, returns it turned by quarter turns.
// Usage:
//   req_i : one request per cycle while ready; op load stores element_value at
//           the next row-major slot, op fetch returns the next element of the
//           rotated matrix on rsp_o. Loads into a full store are dropped silently.
//   rsp_o : one response per fetch; not_ready with value 0 when the matrix is
//           not fully loaded, last_element on the final rotated element, after
//           which a new matrix may be loaded.
//   cfg_i : register 0 matrix_size, register 1 rotation_degrees. Each write
//           holds off requests while the fetch position is re-split into row
//           and column by a serial divider.
// Throughput is one request per cycle while req_i.ready is high, set by the
// single port of the store. A fetch response passes through the synchronous
// store read register and then the output register.
// The store, response register and one pending read decouple the two sides;
// when rsp_o stalls, one more fetch is taken, then req_i.ready drops.
// Reset clears counts, registers to size 4 and angle 0; store contents stay
// undefined until loaded.
`include "square_matrix_rotator_assert.svh"

module square_matrix_rotator #(
  parameter int MAX_DIM = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smr_req_if.sink   req_i,
  smr_rsp_if.source rsp_o,
  smr_cfg_if.sink   cfg_i
);
  import smr_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCW   = $clog2(CW + 1);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0]       size_q;
  logic signed [DEG_W-1:0] deg_q;
  logic [Q_W-1:0]          q_q;
  logic [CW-1:0]           load_q, emit_q;
  logic [RW-1:0]           row_q, col_q;
  logic [DCW-1:0]          div_cnt_q;
  logic [CW-1:0]           quo_q;
  logic [NW-1:0]           rem_q;
  logic                    pend_q, pend_nr_q, pend_last_q;
  logic [VALUE_W-1:0]      rdata_q;
  logic                    out_valid_q, out_last_q, out_nr_q;
  logic [VALUE_W-1:0]      out_value_q;

  logic [SIZE_W:0] n_wide;
  logic [NW-1:0]   n;
  logic [NW-1:0]   nm1;
  logic [RW-1:0]   nm1_r;
  logic [CW-1:0]   total;
  logic            busy, can_move, req_fire, cfg_fire, full;
  logic            do_load, do_fetch, fetch_ok, is_last;
  logic [15:0]     mag, rem360;
  logic [31:0]     prod;
  logic [1:0]      qt, turns;
  logic [RW-1:0]   sr, sc;
  logic [AW-1:0]   rd_addr;
  logic [NW:0]     rem_sh, rem_nx;
  logic            ge;
  logic [CW-1:0]   quo_nx;

  // side length clamp and element count
  always_comb begin
    n_wide = {1'b0, size_q};
    if (size_q == '0) begin
      n_wide = (SIZE_W+1)'(1);
    end else if (n_wide > (SIZE_W+1)'(MAX_DIM)) begin
      n_wide = (SIZE_W+1)'(MAX_DIM);
    end
  end
  assign n     = n_wide[NW-1:0];
  assign nm1   = n - NW'(1);
  assign nm1_r = RW'(nm1);
  assign total = CW'(CW'(n) * CW'(n));

  // quarter turns, second half of a two-stage divide by 360
  assign mag    = deg_q[DEG_W-1] ? 16'(-deg_q) : 16'(deg_q);
  assign prod   = 32'(mag) * RECIP_360;
  assign rem360 = mag - 16'(16'(q_q) * FULL_TURN);
  always_comb begin
    priority if (rem360 >= 16'(3 * QUARTER_TURN)) begin
      qt = TURN_270;
    end else if (rem360 >= 16'(2 * QUARTER_TURN)) begin
      qt = TURN_180;
    end else if (rem360 >= QUARTER_TURN) begin
      qt = TURN_90;
    end else begin
      qt = TURN_0;
    end
  end
  assign turns = deg_q[DEG_W-1] ? (TURN_0 - qt) : qt;

  // read address of the rotated position
  always_comb begin
    unique case (turns)
      TURN_90: begin
        sr = nm1_r - col_q;
        sc = row_q;
      end
      TURN_180: begin
        sr = nm1_r - row_q;
        sc = nm1_r - col_q;
      end
      TURN_270: begin
        sr = col_q;
        sc = nm1_r - row_q;
      end
      default: begin
        sr = row_q;
        sc = col_q;
      end
    endcase
  end
  assign rd_addr = AW'(AW'(sr) * AW'(n)) + AW'(sc);

  assign busy     = (div_cnt_q != '0);
  assign can_move = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !busy && !cfg_i.valid && (!pend_q || can_move);
  assign cfg_i.ready = 1'b1;
  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign full     = (load_q >= total);
  assign do_load  = req_fire && (req_i.op == OP_LOAD) && !full;
  assign do_fetch = req_fire && (req_i.op == OP_FETCH);
  assign fetch_ok = do_fetch && full;
  assign is_last  = (row_q == nm1_r) && (col_q == nm1_r);

  // serial divider step: fetch position over side length
  assign rem_sh = {rem_q, quo_q[CW-1]};
  assign ge     = (rem_sh >= {1'b0, n});
  assign rem_nx = ge ? (rem_sh - {1'b0, n}) : rem_sh;
  assign quo_nx = CW'({quo_q, ge});

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[load_q[AW-1:0]] <= req_i.element_value;
    end
    if (fetch_ok) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      deg_q       <= '0;
      q_q         <= '0;
      load_q      <= '0;
      emit_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      div_cnt_q   <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_nr_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_nr_q    <= 1'b0;
    end else begin
      q_q <= prod[RECIP_SHIFT +: Q_W];

      if (cfg_fire) begin
        unique case (cfg_i.index)
          REG_MATRIX_SIZE:      size_q <= cfg_i.data[SIZE_W-1:0];
          REG_ROTATION_DEGREES: deg_q  <= DEG_W'(cfg_i.data);
          default: ;
        endcase
        div_cnt_q <= DCW'(CW);
        quo_q     <= emit_q;
        rem_q     <= '0;
      end else if (busy) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
        quo_q     <= quo_nx;
        rem_q     <= rem_nx[NW-1:0];
        if (div_cnt_q == DCW'(1)) begin
          if (quo_nx >= CW'(n)) begin
            row_q <= nm1_r;
            col_q <= nm1_r;
          end else begin
            row_q <= RW'(quo_nx);
            col_q <= RW'(rem_nx);
          end
        end
      end

      if (do_load) begin
        load_q <= load_q + CW'(1);
      end

      if (fetch_ok) begin
        if (is_last) begin
          load_q <= '0;
          emit_q <= '0;
          row_q  <= '0;
          col_q  <= '0;
        end else begin
          emit_q <= emit_q + CW'(1);
          if (col_q == nm1_r) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + RW'(1);
          end
        end
      end

      if (pend_q && can_move) begin
        out_valid_q <= 1'b1;
        out_last_q  <= pend_last_q;
        out_nr_q    <= pend_nr_q;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (do_fetch) begin
        pend_q      <= 1'b1;
        pend_nr_q   <= !full;
        pend_last_q <= full && is_last;
      end else if (can_move) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && can_move) begin
      out_value_q <= pend_nr_q ? '0 : rdata_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.last_element = out_last_q;
  assign rsp_o.not_ready    = out_nr_q;

  `SMR_ASSERT(a_pos_in_range, clk_i, rst_ni, busy || ((row_q <= nm1_r) && (col_q <= nm1_r)), "fetch position outside matrix")
  `SMR_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, fetch_ok && is_last, (load_q == '0) && (emit_q == '0), "counts not cleared after last element")
  `SMR_ASSERT(a_nr_zero, clk_i, rst_ni, !(rsp_o.valid && rsp_o.not_ready) || ((rsp_o.result_value == '0) && !rsp_o.last_element), "not-ready response carries data")
  `SMR_ASSERT_NEXT(a_pend_kept, clk_i, rst_ni, pend_q && !can_move, pend_q, "pending read lost under stall")

endmodule

>>> tb/square_matrix_rotator_test.sv
// Testbench for square_matrix_rotator: load/fetch streams checked against a shadow rotation model.
module square_matrix_rotator_test;
  import smr_pkg::*;

  localparam int MAX_DIM      = 32;
  localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] element_value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      last_element;
    logic                      not_ready;
  } element_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smr_req_if req_if ();
  smr_rsp_if rsp_if ();
  smr_cfg_if cfg_if ();

  square_matrix_rotator #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  logic [VALUE_W-1:0]      shadow_matrix [STORE_DEPTH];
  int unsigned             loaded_count;
  int unsigned             fetched_count;
  logic [SIZE_W-1:0]       size_reg;
  logic signed [DEG_W-1:0] angle_reg;

  element_t    expected_elements [$];
  request_t    pending_requests [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned queued_items   = 0;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned side_length();
    int unsigned n;
    n = int'(size_reg);
    if (n == 0) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  // C-style truncating division, so negative angles turn counterclockwise
  function automatic logic [1:0] quarter_turns();
    int deg;
    int turns;
    deg   = int'(angle_reg);
    turns = (deg % int'(FULL_TURN)) / int'(QUARTER_TURN);
    return turns[1:0];
  endfunction

  function automatic void model_request(request_t rq);
    int unsigned n, total, k, r, c, src_r, src_c;
    element_t    e;
    n     = side_length();
    total = n * n;
    if (rq.op == OP_LOAD) begin
      if (loaded_count < total) begin
        shadow_matrix[loaded_count] = rq.element_value;
        loaded_count++;
      end
    end else if (loaded_count < total) begin
      e.result_value = '0;
      e.last_element = 1'b0;
      e.not_ready    = 1'b1;
      expected_elements.push_back(e);
    end else begin
      // index clamps to the final element if the size shrank meanwhile
      k = (fetched_count > total - 1) ? total - 1 : fetched_count;
      r = k / n;
      c = k % n;
      case (quarter_turns())
        TURN_90: begin
          src_r = n - 1 - c;
          src_c = r;
        end
        TURN_180: begin
          src_r = n - 1 - r;
          src_c = n - 1 - c;
        end
        TURN_270: begin
          src_r = c;
          src_c = n - 1 - r;
        end
        default: begin
          src_r = r;
          src_c = c;
        end
      endcase
      e.result_value = shadow_matrix[src_r * n + src_c];
      e.last_element = (k == total - 1);
      e.not_ready    = 1'b0;
      expected_elements.push_back(e);
      if (e.last_element) begin
        loaded_count  = 0;
        fetched_count = 0;
      end else begin
        fetched_count = k + 1;
      end
    end
  endfunction

  function automatic void check_element(element_t got);
    element_t want;
    if (expected_elements.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected response: value %0d last %0b not_ready %0b",
                 got.result_value, got.last_element, got.not_ready);
    end else begin
      want = expected_elements.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("mismatch: expected value %0d last %0b not_ready %0b, got value %0d last %0b not_ready %0b",
                   want.result_value, want.last_element, want.not_ready,
                   got.result_value, got.last_element, got.not_ready);
      end
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.op            <= OP_LOAD;
      req_if.element_value <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid                         <= 1'b1;
        {req_if.op, req_if.element_value} <= pending_requests.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        model_request(request_t'({req_if.op, req_if.element_value}));
      if (rsp_if.valid && rsp_if.ready)
        check_element(element_t'({rsp_if.result_value, rsp_if.last_element,
                                  rsp_if.not_ready}));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_request(logic op, logic [VALUE_W-1:0] value);
    request_t rq;
    rq.op            = op;
    rq.element_value = value;
    pending_requests.push_back(rq);
    queued_items++;
  endtask

  task automatic load_values(int unsigned count);
    repeat (count) push_request(OP_LOAD, $urandom);
  endtask

  task automatic fetch_values(int unsigned count);
    repeat (count) push_request(OP_FETCH, $urandom);
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_requests.size() > 0 || req_if.valid || expected_elements.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_quiet();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MATRIX_SIZE) begin
      size_reg = value[SIZE_W-1:0];
    end else begin
      angle_reg = value;
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return CFG_DATA_W'($urandom_range(1, 6));
    if (pick < 95) return CFG_DATA_W'($urandom_range(7, 12));
    return '0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_angle();
    logic signed [DEG_W-1:0] notable [12];
    notable = '{16'sd0, 16'sd90, 16'sd180, 16'sd270, -16'sd90, -16'sd180, -16'sd270,
                16'sd359, 16'sd360, -16'sd360, 16'sd89, -16'sd89};
    if ($urandom_range(1)) return notable[$urandom_range(11)];
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic random_episode();
    int unsigned n, total, shrunk;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) push_request(1'($urandom_range(1)), $urandom);
    end else begin
      if ($urandom_range(99) < 50) write_register(REG_MATRIX_SIZE, random_size());
      if ($urandom_range(99) < 50) write_register(REG_ROTATION_DEGREES, random_angle());
      n     = side_length();
      total = n * n;
      if ($urandom_range(99) < 10) fetch_values(1);
      load_values(total);
      if ($urandom_range(99) < 20) load_values($urandom_range(1, 3));
      if (n > 1 && $urandom_range(99) < 10) begin
        fetch_values($urandom_range(1, total - 1));
        shrunk = $urandom_range(1, n - 1);
        write_register(REG_MATRIX_SIZE, CFG_DATA_W'(shrunk));
        fetch_values(shrunk * shrunk);
      end else begin
        repeat (total) begin
          fetch_values(1);
          if ($urandom_range(99) < 5) load_values(1);
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_end;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.op            = OP_LOAD;
    req_if.element_value = '0;
    rsp_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_MATRIX_SIZE;
    cfg_if.data          = '0;
    loaded_count         = 0;
    fetched_count        = 0;
    size_reg             = SIZE_RESET;
    angle_reg            = '0;
    send_idle_pct        = 6;
    recv_idle_pct        = 63;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    fetch_values(1);
    write_register(REG_MATRIX_SIZE, 16'd0);
    write_register(REG_ROTATION_DEGREES, 16'h7FFF);
    push_request(OP_LOAD, 32'h8000_0000);
    push_request(OP_LOAD, 32'h7FFF_FFFF);
    fetch_values(1);
    write_register(REG_MATRIX_SIZE, 16'd2);
    write_register(REG_ROTATION_DEGREES, 16'd90);
    push_request(OP_LOAD, 32'h7FFF_FFFF);
    push_request(OP_LOAD, 32'hFFFF_FFFF);
    push_request(OP_LOAD, 32'h0000_0000);
    push_request(OP_LOAD, 32'h0000_0001);
    fetch_values(2);
    write_register(REG_ROTATION_DEGREES, 16'd180);
    fetch_values(2);
    write_register(REG_ROTATION_DEGREES, 16'(-90));
    load_values(4);
    fetch_values(1);
    write_register(REG_MATRIX_SIZE, 16'd63);
    fetch_values(1);
    load_values(1);
    write_register(REG_MATRIX_SIZE, 16'd1);
    write_register(REG_ROTATION_DEGREES, 16'h8000);
    fetch_values(1);

    // random phases, then a full-size matrix with no idle cycles
    for (int phase = 0; phase < 3; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_register(REG_MATRIX_SIZE, CFG_DATA_W'(MAX_DIM));
          write_register(REG_ROTATION_DEGREES, 16'd270);
          load_values(STORE_DEPTH);
          fetch_values(2 * MAX_DIM);
        end
      endcase
      if (phase < 2) begin
        phase_end = queued_items + RANDOM_ITEMS / 2;
        while (queued_items < phase_end) random_episode();
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
